@@ rtl/breakpoint_envelope_interpolator_assert.svh @@
// assertion macros for the breakpoint envelope interpolator
// used inside modules that have clk and arst_n in scope
`ifndef BREAKPOINT_ENVELOPE_INTERPOLATOR_ASSERT_SVH
`define BREAKPOINT_ENVELOPE_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define BEI_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bei assertion failed");

// next-cycle implication
`define BEI_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bei assertion failed");

`endif

@@ rtl/bei_pkg.sv @@
// shared types, constants and command codes of the breakpoint envelope interpolator
// no dependencies
`timescale 1ns / 1ps
package bei_pkg;
	localparam int TABLE_DEPTH = 64;
	localparam int ALPHA_BITS = 16;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int SLOT_W = 6;
	localparam int ALPHA_W = ALPHA_BITS + 1;
	localparam int MULX_W = (ALPHA_W > 32) ? ALPHA_W : 32;
	localparam int PROD_W = MULX_W + 32;
	localparam int ACC_W = ALPHA_W + 32;
	localparam int DIVD_W = 32 + ALPHA_BITS;
	localparam int DCNT_W = $clog2(DIVD_W + 1);

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [3:0] OP_NOP = 4'd0;
	localparam logic [3:0] OP_LOAD = 4'd1;
	localparam logic [3:0] OP_SRCH_RD = 4'd2;
	localparam logic [3:0] OP_SRCH_CMP = 4'd3;
	localparam logic [3:0] OP_WRITE = 4'd4;
	localparam logic [3:0] OP_FULL = 4'd5;
	localparam logic [3:0] OP_EMPTY = 4'd6;
	localparam logic [3:0] OP_SHIFT_RD = 4'd7;
	localparam logic [3:0] OP_SHIFT_WR = 4'd8;
	localparam logic [3:0] OP_RD_LO = 4'd9;
	localparam logic [3:0] OP_LAT_LO = 4'd10;
	localparam logic [3:0] OP_RD_HI = 4'd11;
	localparam logic [3:0] OP_LAT_HI = 4'd12;
	localparam logic [3:0] OP_DIV_INIT = 4'd13;
	localparam logic [3:0] OP_DIV_STEP = 4'd14;

	localparam logic [2:0] MS_AHF = 3'd0;
	localparam logic [2:0] MS_BLF = 3'd1;
	localparam logic [2:0] MS_AHA = 3'd2;
	localparam logic [2:0] MS_BLA = 3'd3;
	localparam logic [2:0] MS_AHB = 3'd4;
	localparam logic [2:0] MS_BLB = 3'd5;
	localparam logic [2:0] MS_PH = 3'd6;
	localparam logic [2:0] MS_EXT = 3'd7;

	typedef struct packed {
		logic [31:0] p;
		logic [15:0] b;
		logic [15:0] a;
		logic [31:0] f;
		logic [31:0] t;
	} entry_t;

	typedef struct packed {
		logic [31:0] phase;
		logic [15:0] bandwidth;
		logic [15:0] amplitude;
		logic [31:0] frequency;
		logic [SLOT_W-1:0] slot;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		logic [3:0] op;
		logic mul_go;
		logic [2:0] mul_sel;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_query;
		logic srch_more;
		logic eq;
		logic full;
		logic empty;
		logic pos_zero;
		logic pos_past;
		logic shift_more;
		logic div_last;
	} sts_t;
endpackage

@@ rtl/bei_dp.sv @@
// datapath: breakpoint memory, search, shift, serial divider, shared multiplier
// depends on bei_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "breakpoint_envelope_interpolator_assert.svh"
module bei_dp import bei_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_kind,
	input entry_t in_entry,
	input cmd_t cmd,
	output sts_t sts,
	output result_t out_res
);
	entry_t mem [TABLE_DEPTH];
	entry_t rd_q, lo_e_q, hi_e_q, in_q;
	logic kind_q, eq_q;
	logic [CNT_W-1:0] count_q, lo_q, hi_q, k_q, mid;
	logic [IDX_W-1:0] ra, wa;
	logic we;
	entry_t wd;
	result_t res_q, out_q;
	logic [DIVD_W-1:0] divd_q;
	logic [31:0] rem_q;
	logic [32:0] rem_sh;
	logic [31:0] span_q, dt, favg_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic ge;
	logic [ALPHA_W-1:0] alpha, alpha_c;
	logic [MULX_W-1:0] mul_x;
	logic [31:0] mul_y;
	logic [PROD_W-1:0] prod_s1;
	logic [2:0] sel_s1;
	logic vld_s1;
	logic [ACC_W-1:0] acc_q, raw;
	logic [ACC_W:0] q_sum;
	logic pos_zero, pos_past;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign pos_zero = (lo_q == '0);
	assign pos_past = (lo_q >= count_q);
	assign dt = pos_zero ? (lo_e_q.t - in_q.t) : (in_q.t - lo_e_q.t);
	assign alpha = divd_q[ALPHA_W-1:0];
	assign alpha_c = ALPHA_W'(1 << ALPHA_BITS) - alpha;
	assign rem_sh = {rem_q, divd_q[DIVD_W-1]};
	assign ge = rem_sh >= {1'b0, span_q};

	always_comb begin
		sts.is_query = kind_q;
		sts.srch_more = lo_q < hi_q;
		sts.eq = eq_q;
		sts.full = count_q == CNT_W'(TABLE_DEPTH);
		sts.empty = count_q == '0;
		sts.pos_zero = pos_zero;
		sts.pos_past = pos_past;
		sts.shift_more = k_q > lo_q;
		sts.div_last = dcnt_q == DCNT_W'(1);
	end

	always_comb begin
		ra = '0;
		we = 1'b0;
		wa = lo_q[IDX_W-1:0];
		wd = in_q;
		unique case (cmd.op)
			OP_SRCH_RD: ra = mid[IDX_W-1:0];
			OP_SHIFT_RD: ra = IDX_W'(k_q - 1'b1);
			OP_RD_LO: begin
				if (pos_zero)
					ra = '0;
				else if (pos_past)
					ra = IDX_W'(count_q - 1'b1);
				else
					ra = IDX_W'(lo_q - 1'b1);
			end
			OP_RD_HI: ra = lo_q[IDX_W-1:0];
			OP_SHIFT_WR: begin
				we = 1'b1;
				wa = k_q[IDX_W-1:0];
				wd = rd_q;
			end
			OP_WRITE: we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	always_comb begin
		mul_x = MULX_W'(dt);
		mul_y = favg_q;
		unique case (cmd.mul_sel)
			MS_AHF: begin mul_x = MULX_W'(alpha); mul_y = hi_e_q.f; end
			MS_BLF: begin mul_x = MULX_W'(alpha_c); mul_y = lo_e_q.f; end
			MS_AHA: begin mul_x = MULX_W'(alpha); mul_y = 32'(hi_e_q.a); end
			MS_BLA: begin mul_x = MULX_W'(alpha_c); mul_y = 32'(lo_e_q.a); end
			MS_AHB: begin mul_x = MULX_W'(alpha); mul_y = 32'(hi_e_q.b); end
			MS_BLB: begin mul_x = MULX_W'(alpha_c); mul_y = 32'(lo_e_q.b); end
			MS_PH: mul_y = favg_q;
			MS_EXT: mul_y = lo_e_q.f;
			default: ;
		endcase
	end

	assign raw = acc_q + prod_s1[ACC_W-1:0];
	assign q_sum = (ACC_W+1)'(raw >> ALPHA_BITS) + (ACC_W+1)'(lo_e_q.f) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.mul_go;
			if (cmd.op == OP_WRITE && !eq_q)
				count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(mul_x) * PROD_W'(mul_y);
		sel_s1 <= cmd.mul_sel;
		if (cmd.load_out)
			out_q <= res_q;
		unique case (cmd.op)
			OP_LOAD: begin
				in_q <= in_entry;
				kind_q <= in_kind;
				lo_q <= '0;
				hi_q <= count_q;
				k_q <= count_q;
				eq_q <= 1'b0;
				res_q <= '0;
			end
			OP_SRCH_CMP: begin
				if (rd_q.t < in_q.t)
					lo_q <= mid + 1'b1;
				else begin
					hi_q <= mid;
					eq_q <= rd_q.t == in_q.t;
				end
			end
			OP_SHIFT_WR: k_q <= k_q - 1'b1;
			OP_WRITE: res_q.slot <= SLOT_W'(lo_q);
			OP_FULL: begin
				res_q.status <= ST_FULL;
				res_q.slot <= SLOT_W'(lo_q);
			end
			OP_EMPTY: res_q.status <= ST_EMPTY;
			OP_LAT_LO: begin
				lo_e_q <= rd_q;
				res_q.slot <= pos_zero ? '0 : SLOT_W'(count_q - 1'b1);
				res_q.frequency <= rd_q.f;
				res_q.bandwidth <= rd_q.b;
			end
			OP_RD_HI: lo_e_q <= rd_q;
			OP_LAT_HI: begin
				hi_e_q <= rd_q;
				res_q.slot <= SLOT_W'(lo_q);
			end
			OP_DIV_INIT: begin
				span_q <= (hi_e_q.t == lo_e_q.t) ? 32'd1 : (hi_e_q.t - lo_e_q.t);
				divd_q <= {dt, {ALPHA_BITS{1'b0}}};
				rem_q <= '0;
				dcnt_q <= DCNT_W'(DIVD_W);
			end
			OP_DIV_STEP: begin
				rem_q <= ge ? 32'(rem_sh - {1'b0, span_q}) : rem_sh[31:0];
				divd_q <= {divd_q[DIVD_W-2:0], ge};
				dcnt_q <= dcnt_q - 1'b1;
			end
			default: ;
		endcase
		if (vld_s1) begin
			unique case (sel_s1)
				MS_AHF, MS_AHA, MS_AHB: acc_q <= prod_s1[ACC_W-1:0];
				MS_BLF: begin
					res_q.frequency <= 32'((raw + ACC_W'(1 << (ALPHA_BITS - 1))) >> ALPHA_BITS);
					favg_q <= 32'(q_sum >> 1);
				end
				MS_BLA: res_q.amplitude <=
					16'((raw + ACC_W'(1 << (ALPHA_BITS - 1))) >> ALPHA_BITS);
				MS_BLB: res_q.bandwidth <=
					16'((raw + ACC_W'(1 << (ALPHA_BITS - 1))) >> ALPHA_BITS);
				MS_PH: res_q.phase <= lo_e_q.p + prod_s1[31:0];
				MS_EXT: res_q.phase <= pos_zero ? (lo_e_q.p - prod_s1[31:0])
					: (lo_e_q.p + prod_s1[31:0]);
				default: ;
			endcase
		end
	end

	assign out_res = out_q;

	`BEI_ASSERT_IMP(a_count_range, 1'b1, count_q <= CNT_W'(TABLE_DEPTH))
	`BEI_ASSERT_NXT(a_count_grow, cmd.op == OP_WRITE && !eq_q, count_q == $past(count_q) + 1'b1)
	`BEI_ASSERT_IMP(a_div_count, cmd.op == OP_DIV_STEP, dcnt_q != '0)
endmodule

@@ rtl/bei_ctrl.sv @@
// controller state machine: sequences search, shift, divide and blend steps
// depends on bei_pkg
`timescale 1ns / 1ps
module bei_ctrl import bei_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input logic m_tready,
	input sts_t sts,
	output cmd_t cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SRCH = 4'd1;
	localparam logic [3:0] S_CMP = 4'd2;
	localparam logic [3:0] S_DISP = 4'd3;
	localparam logic [3:0] S_SHRD = 4'd4;
	localparam logic [3:0] S_SHWR = 4'd5;
	localparam logic [3:0] S_WRITE = 4'd6;
	localparam logic [3:0] S_RDLO = 4'd7;
	localparam logic [3:0] S_LATLO = 4'd8;
	localparam logic [3:0] S_EXT = 4'd9;
	localparam logic [3:0] S_RDHI = 4'd10;
	localparam logic [3:0] S_LATHI = 4'd11;
	localparam logic [3:0] S_DIV = 4'd12;
	localparam logic [3:0] S_MUL = 4'd13;
	localparam logic [3:0] S_DRAIN = 4'd14;
	localparam logic [3:0] S_DONE = 4'd15;

	logic [3:0] state_q, state_d;
	logic [2:0] mstep_q, mstep_d;
	logic out_vld_q;

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = out_vld_q;

	always_comb begin
		state_d = state_q;
		mstep_d = mstep_q;
		cmd = '0;
		cmd.op = OP_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.op = OP_LOAD;
					state_d = S_SRCH;
				end
			end
			S_SRCH: begin
				if (sts.srch_more) begin
					cmd.op = OP_SRCH_RD;
					state_d = S_CMP;
				end else
					state_d = S_DISP;
			end
			S_CMP: begin
				cmd.op = OP_SRCH_CMP;
				state_d = S_SRCH;
			end
			S_DISP: begin
				if (sts.is_query) begin
					if (sts.empty) begin
						cmd.op = OP_EMPTY;
						state_d = S_DONE;
					end else
						state_d = S_RDLO;
				end else if (sts.eq)
					state_d = S_WRITE;
				else if (sts.full) begin
					cmd.op = OP_FULL;
					state_d = S_DONE;
				end else if (sts.shift_more)
					state_d = S_SHRD;
				else
					state_d = S_WRITE;
			end
			S_SHRD: begin
				cmd.op = OP_SHIFT_RD;
				state_d = S_SHWR;
			end
			S_SHWR: begin
				cmd.op = OP_SHIFT_WR;
				state_d = S_DISP;
			end
			S_WRITE: begin
				cmd.op = OP_WRITE;
				state_d = S_DONE;
			end
			S_RDLO: begin
				cmd.op = OP_RD_LO;
				state_d = (sts.pos_zero || sts.pos_past) ? S_LATLO : S_RDHI;
			end
			S_LATLO: begin
				cmd.op = OP_LAT_LO;
				state_d = S_EXT;
			end
			S_EXT: begin
				cmd.mul_go = 1'b1;
				cmd.mul_sel = MS_EXT;
				state_d = S_DRAIN;
			end
			S_RDHI: begin
				cmd.op = OP_RD_HI;
				state_d = S_LATHI;
			end
			S_LATHI: begin
				cmd.op = OP_LAT_HI;
				state_d = S_DIV;
				mstep_d = MS_AHF;
			end
			S_DIV: begin
				if (mstep_q == MS_AHF) begin
					cmd.op = OP_DIV_INIT;
					mstep_d = MS_BLF;
				end else begin
					cmd.op = OP_DIV_STEP;
					if (sts.div_last) begin
						state_d = S_MUL;
						mstep_d = MS_AHF;
					end
				end
			end
			S_MUL: begin
				cmd.mul_go = 1'b1;
				cmd.mul_sel = mstep_q;
				mstep_d = mstep_q + 1'b1;
				if (mstep_q == MS_PH)
					state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_DONE;
			S_DONE: begin
				if (!out_vld_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mstep_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mstep_q <= mstep_d;
			if (cmd.load_out)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
		end
	end
endmodule

@@ rtl/breakpoint_envelope_interpolator.sv @@
// channel  | signals                         | contents
// s (in)   | s_tvalid s_tready s_tdata s_tuser | insert or query beat
// m (out)  | m_tvalid m_tready m_tdata       | status, slot and interpolated values
// one item at a time; each binary-search probe reads, then compares, the middle entry
// insert shifts the table tail, reading then writing each entry moved
// interior query: alpha comes from the 48-step serial divider
// extrapolated query skips the divider; output register lets a new beat enter
// while the result waits; reset clears the entry count and control flags, not the table
// top level of the breakpoint envelope interpolator
// depends on bei_pkg, bei_ctrl and bei_dp
`timescale 1ns / 1ps
module breakpoint_envelope_interpolator import bei_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [127:0] s_tdata, // at_time, frequency_in, amplitude_in, bandwidth_in, phase_in
	input logic s_tuser, // kind
	output logic m_tvalid,
	input logic m_tready,
	output logic [103:0] m_tdata // status, slot_index, frequency_out, amplitude_out,
	                             // bandwidth_out, phase_out
);
	cmd_t cmd;
	sts_t sts;
	result_t res;

	bei_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts(sts),
		.cmd(cmd)
	);

	bei_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_kind(s_tuser),
		.in_entry(entry_t'(s_tdata)),
		.cmd(cmd),
		.sts(sts),
		.out_res(res)
	);

	assign m_tdata = res;
endmodule
